[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue: request and response
// payloads, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	// default number of cells
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned PRIO_W    = 16;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned OCC_W     = 5;

	typedef logic signed [PRIO_W-1:0] prio_t;
	typedef logic [PAYLOAD_W-1:0]     payload_t;

	// operation codes
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// status codes
	typedef enum logic [1:0] {
		ST_PUSHED     = 2'd0,
		ST_POPPED     = 2'd1,
		ST_POP_EMPTY  = 2'd2,
		ST_PUSH_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		op_t      operation;
		prio_t    priority_req;
		payload_t payload;
	} req_t;

	typedef struct packed {
		status_t         status;
		payload_t        popped_payload;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic     push;
		logic     pop;
		prio_t    new_prio;
		payload_t new_payload;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[sv/spq_req_if.sv]
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel of the sorted priority queue: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
	logic          valid;
	logic          ready;
	spq_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/spq_rsp_if.sv]
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel of the sorted priority queue: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if;
	logic          valid;
	logic          ready;
	spq_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift register. On a push the cell keeps its entry,
// takes the new entry, or takes its left neighbor's; on a pop it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire logic                clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire logic                occupied,
	input  wire logic                left_after,
	input  wire spq_pkg::prio_t      left_prio,
	input  wire spq_pkg::payload_t   left_payload,
	input  wire spq_pkg::prio_t      right_prio,
	input  wire spq_pkg::payload_t   right_payload,
	output      logic                after,
	output      spq_pkg::prio_t      prio,
	output      spq_pkg::payload_t   payload
);

	spq_pkg::prio_t    prio_q;
	spq_pkg::payload_t payload_q;

	// new entry goes behind this one when ours is not larger
	assign after   = occupied && (prio_q <= ctrl.new_prio);
	assign prio    = prio_q;
	assign payload = payload_q;

	// entry update
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!after) begin
				if (left_after) begin
					prio_q    <= ctrl.new_prio;
					payload_q <= ctrl.new_payload;
				end else begin
					prio_q    <= left_prio;
					payload_q <= left_payload;
				end
			end
		end else if (ctrl.pop) begin
			prio_q    <= right_prio;
			payload_q <= right_payload;
		end
	end

endmodule

`default_nettype wire

[sv/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue built as a row of cells kept in sorted order.
// ----------------------------------------------------------------------------
// The queue takes one request per clock cycle, push or pop, and returns one
// response per request in the cycle after it is accepted; the response sits
// in an output register, so a new request is taken whenever that register is
// empty or being drained in the same cycle. Every cell compares the pushed
// priority with its own entry in parallel and shifts by at most one place, so
// the cost of a request does not grow with QUEUE_DEPTH: the critical path is
// one 16-bit compare plus a two-level select per cell. The smallest priority
// leaves first, equal priorities leave in arrival order, a pop on an empty
// queue reports empty and a push into a full queue is dropped and flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core #(
	parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_next;
	logic                rsp_valid_q;
	spq_pkg::rsp_t       rsp_q;
	spq_pkg::rsp_t       rsp_next;
	spq_pkg::cell_ctrl_t ctrl;
	logic                fire;
	logic                full;
	logic                empty;
	logic [CW+spq_pkg::OCC_W-1:0] occ_wide;

	spq_pkg::prio_t    cell_prio    [QUEUE_DEPTH];
	spq_pkg::payload_t cell_payload [QUEUE_DEPTH];
	logic              cell_after   [QUEUE_DEPTH];

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	// cell control broadcast
	always_comb begin
		ctrl.push        = fire && (req.data.operation == spq_pkg::OP_PUSH) && !full;
		ctrl.pop         = fire && (req.data.operation == spq_pkg::OP_POP) && !empty;
		ctrl.new_prio    = req.data.priority_req;
		ctrl.new_payload = req.data.payload;
	end

	// cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              l_after;
		spq_pkg::prio_t    l_prio;
		spq_pkg::payload_t l_payload;
		spq_pkg::prio_t    r_prio;
		spq_pkg::payload_t r_payload;

		if (i == 0) begin : g_head
			assign l_after   = 1'b1;
			assign l_prio    = '0;
			assign l_payload = '0;
		end else begin : g_mid
			assign l_after   = cell_after[i-1];
			assign l_prio    = cell_prio[i-1];
			assign l_payload = cell_payload[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_prio    = '0;
			assign r_payload = '0;
		end else begin : g_body
			assign r_prio    = cell_prio[i+1];
			assign r_payload = cell_payload[i+1];
		end

		spq_cell u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (CW'(i) < count_q),
			.left_after    (l_after),
			.left_prio     (l_prio),
			.left_payload  (l_payload),
			.right_prio    (r_prio),
			.right_payload (r_payload),
			.after         (cell_after[i]),
			.prio          (cell_prio[i]),
			.payload       (cell_payload[i])
		);
	end

	// occupancy update
	always_comb begin
		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_next = count_q - CW'(1);
		end
	end

	assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

	// response build
	always_comb begin
		rsp_next.popped_payload = '0;
		rsp_next.occupancy      = occ_wide[spq_pkg::OCC_W-1:0];
		case (req.data.operation)
			spq_pkg::OP_PUSH: begin
				rsp_next.status = full ? spq_pkg::ST_PUSH_FULL : spq_pkg::ST_PUSHED;
			end
			spq_pkg::OP_POP: begin
				if (empty) begin
					rsp_next.status = spq_pkg::ST_POP_EMPTY;
				end else begin
					rsp_next.status         = spq_pkg::ST_POPPED;
					rsp_next.popped_payload = cell_payload[0];
				end
			end
			default: begin
				rsp_next.status = spq_pkg::ST_PUSHED;
			end
		endcase
	end

	// count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// count stays within the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// a push into a non-full queue grows it by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.data.operation == spq_pkg::OP_PUSH && !full
		|=> count_q == $past(count_q) + CW'(1))
		else $error("push did not add an entry");

	// head pair stays sorted
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> cell_prio[0] <= cell_prio[1])
		else $error("head entries out of order");

	// only a pop that removed an entry returns a payload
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != spq_pkg::ST_POPPED |-> rsp_q.popped_payload == '0)
		else $error("payload returned without a pop");

endmodule

`default_nettype wire

[dv/sorted_priority_queue_checker.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches the request and response channels of the sorted priority queue,
// keeps a shadow copy of the sorted entries, predicts each response and
// compares it field by field with what the queue returns.
// ----------------------------------------------------------------------------

module sorted_priority_queue_checker #(
	parameter int unsigned DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	spq_req_if               req_mon,
	spq_rsp_if               rsp_mon,
	output int unsigned      fails,
	output int unsigned      outstanding,
	output logic [3:0][31:0] status_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	// shadow of the sorted entries, head at index 0
	prio_t       shadow_prio [DEPTH];
	payload_t    shadow_tag  [DEPTH];
	int unsigned shadow_count;

	// predicted responses in request order
	rsp_t awaited_rsps [$];

	// apply one request to the shadow queue and return its response
	function automatic rsp_t shadow_apply(req_t r);
		rsp_t res;
		int unsigned slot;
		res = '0;
		if (r.operation == OP_PUSH) begin
			if (shadow_count >= DEPTH) begin
				res.status = ST_PUSH_FULL;
			end else begin
				// new entry goes behind every entry of lower or equal priority
				slot = 0;
				while (slot < shadow_count && shadow_prio[slot] <= r.priority_req)
					slot++;
				for (int unsigned i = shadow_count; i > slot; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_tag[i]  = shadow_tag[i-1];
				end
				shadow_prio[slot] = r.priority_req;
				shadow_tag[slot]  = r.payload;
				shadow_count++;
				res.status = ST_PUSHED;
			end
		end else if (shadow_count == 0) begin
			res.status = ST_POP_EMPTY;
		end else begin
			res.status         = ST_POPPED;
			res.popped_payload = shadow_tag[0];
			for (int unsigned i = 1; i < shadow_count; i++) begin
				shadow_prio[i-1] = shadow_prio[i];
				shadow_tag[i-1]  = shadow_tag[i];
			end
			shadow_count--;
		end
		res.occupancy = shadow_count[OCC_W-1:0];
		return res;
	endfunction

	task automatic flag_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			fails++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, field, want_v, got_v);
		end
	endtask

	// predict on each accepted request, compare on each accepted response
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			shadow_count = 0;
			awaited_rsps.delete();
			fails       = 0;
			status_hits = '0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				awaited_rsps.push_back(shadow_apply(req_mon.data));
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = rsp_mon.data;
				if (awaited_rsps.size() == 0) begin
					fails++;
					$display("%0t: response with no request pending: expected none, got %h",
						$time, got);
				end else begin
					want = awaited_rsps.pop_front();
					status_hits[want.status] = status_hits[want.status] + 1;
					flag_field("status", 32'(want.status), 32'(got.status));
					flag_field("popped_payload", want.popped_payload, got.popped_payload);
					flag_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
				end
			end
		end
		outstanding = awaited_rsps.size();
	end

endmodule

[dv/sorted_priority_queue_core_test.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Drives push and pop requests into the sorted priority queue with random
// gaps and response stalls; a checker beside the block predicts and compares
// every response. Directed requests cover empty, full, extreme and tied
// priorities, then random phases fill, drain and churn the queue.
// ----------------------------------------------------------------------------

module sorted_priority_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int unsigned DEPTH           = QUEUE_DEPTH_DEF;
	localparam int unsigned RANDOM_REQUESTS = 650;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// set during stretches with no idling on either side
	bit steady = 1'b0;

	int unsigned      sent;
	int unsigned      fails;
	int unsigned      outstanding;
	logic [3:0][31:0] status_hits;

	// priorities that fill the queue: extremes, ties and mixed signs
	prio_t fill_prio [16] = '{
		16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0005, 16'sh0005, 16'sh0005,
		-16'sh8000, 16'sh7fff, 16'sh0001, 16'sh0064, -16'sh0064, 16'sh0000, 16'sh0007,
		-16'sh0007, 16'sh0003
	};

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue_core #(
		.QUEUE_DEPTH (DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_priority_queue_checker #(
		.DEPTH (DEPTH)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_mon     (req_ch),
		.rsp_mon     (rsp_ch),
		.fails       (fails),
		.outstanding (outstanding),
		.status_hits (status_hits)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned idle_cycles();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// partly a narrow band for ties, some extremes, mostly full range
	function automatic prio_t pick_priority();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return prio_t'(int'($urandom_range(0, 4)) - 2);
			end
			3: begin
				case ($urandom_range(0, 3))
					0: return -16'sh8000;
					1: return 16'sh7fff;
					2: return -16'sh0001;
					default: return 16'sh0000;
				endcase
			end
			default: begin
				return prio_t'($urandom);
			end
		endcase
	endfunction

	// present one request after a random gap and hold it until taken
	task automatic send(op_t op, prio_t p, payload_t tag);
		int unsigned gap;
		req_t r;
		gap = idle_cycles();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r.operation    = op;
		r.priority_req = p;
		r.payload      = tag;
		req_ch.data  <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	// request stimulus and verdict
	initial begin
		int unsigned push_pct;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		sent         = 0;
		push_pct     = 50;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pop on empty, fill to the brim, push on full, then pops
		send(OP_POP, 16'sh7fff, 32'hffff_ffff);
		for (int i = 0; i < DEPTH; i++)
			send(OP_PUSH, fill_prio[i % 16],
				(i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hffff_ffff : 32'h5a00_0000 + i);
		send(OP_PUSH, -16'sh8000, 32'hdead_0001);
		for (int i = 0; i < 5; i++)
			send(OP_POP, prio_t'($urandom), $urandom);

		// random phases biased to fill, drain or churn
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 50;
				endcase
				steady = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < push_pct)
				send(OP_PUSH, pick_priority(), $urandom);
			else
				send(OP_POP, pick_priority(), $urandom);
		end

		// drain remaining responses
		req_ch.valid <= 1'b0;
		steady = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("ran %0d requests: directed empty, full, extreme and tied priorities, "
			, sent, "then random fill, drain and churn phases");
		$display("responses: %0d pushed, %0d popped, %0d pops on empty, %0d pushes dropped",
			status_hits[ST_PUSHED], status_hits[ST_POPPED], status_hits[ST_POP_EMPTY],
			status_hits[ST_PUSH_FULL]);
		if (fails == 0)
			$display("sorted_priority_queue_core_test: done, clean");
		else
			$display("sorted_priority_queue_core_test: done, errors");
		$finish;
	end

	// response side stalls
	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles();
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("sorted_priority_queue_core_test: done, errors");
		$finish;
	end

endmodule
